### hw/rtl/touch_poll_event_qualifier_top_defines.svh
// Assertion helpers for the touch poll event qualifier.
`ifndef TOUCH_POLL_EVENT_QUALIFIER_TOP_DEFINES_SVH
`define TOUCH_POLL_EVENT_QUALIFIER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TPEQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tpeq assertion failed");

// Next-cycle implication, disabled while reset is high.
`define TPEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tpeq assertion failed");

`endif

### hw/rtl/tpeq_pkg.sv
package tpeq_pkg;

   localparam int unsigned TIME_W  = 64;
   localparam int unsigned DELAY_W = 16;
   localparam int unsigned LIMIT_W = 8;
   localparam int unsigned POLL_W  = 20;
   localparam int unsigned COORD_W = 16;
   localparam int unsigned SIZE_W  = 16;
   localparam int unsigned CNT_W   = 3;
   localparam int unsigned CSR_W   = 20;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [DELAY_W-1:0] RELEASE_DELAY_RST  = 16'd20;
   localparam logic [DELAY_W-1:0] RETRY_INTERVAL_RST = 16'd1000;
   localparam logic [LIMIT_W-1:0] FAIL_LIMIT_RST     = 8'd20;
   localparam logic [POLL_W-1:0]  POLL_MIN_RST       = 20'd8000;
   localparam logic [POLL_W-1:0]  POLL_MAX_RST       = 20'd50000;

   // bytes of one mailbox record handed to the host
   localparam logic [SIZE_W-1:0]  RECORD_BYTES = 16'd6;

   typedef enum logic {
      KIND_POLL = 1'b0,
      KIND_HOST = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      RD_OK     = 2'd0,
      RD_NODATA = 2'd1,
      RD_NORESP = 2'd2,
      RD_ERROR  = 2'd3
   } rd_result_type;

   typedef enum logic [1:0] {
      HOST_DELIVERED = 2'd0,
      HOST_EMPTY     = 2'd1,
      HOST_SMALL     = 2'd2
   } host_status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RELEASE_DELAY  = 3'd0,
      CSR_RETRY_INTERVAL = 3'd1,
      CSR_FAIL_LIMIT     = 3'd2,
      CSR_POLL_MIN       = 3'd3,
      CSR_POLL_MAX       = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic                ready_res;
      logic                pending;
      logic                pressed;
      logic [COORD_W-1:0]  out_x;
      logic [COORD_W-1:0]  out_y;
      logic                wakeup;
      logic                init_tried;
      logic                link_drop;
      logic [POLL_W-1:0]   sleep_us;
      host_status_type     host_status;
   } result_type;

endpackage

### hw/rtl/touch_poll_event_qualifier_top.sv
// A transaction accepted into the input register lands in the result register as soon as
//   the result slot is empty or draining.
// Throughput: one transaction per cycle while the consumer takes results; the input register doubles as a skid stage,
//   so a new transaction is taken while a finished result waits for the consumer.
// Reset (synchronous, active high): clears both stages, restores register defaults,
//   and returns the tracker to offline with an empty mailbox.
`include "touch_poll_event_qualifier_top_defines.svh"

module touch_poll_event_qualifier_top
   import tpeq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   // input transactions
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_kind,
   input  logic [TIME_W-1:0]     req_now_ms,
   input  logic                  req_init_ok,
   input  logic [1:0]            req_read_result,
   input  logic [CNT_W-1:0]      req_point_count,
   input  logic [COORD_W-1:0]    req_touch_x,
   input  logic [COORD_W-1:0]    req_touch_y,
   input  logic [SIZE_W-1:0]     req_read_size,

   // result transactions
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_ready_res,
   output logic                  rsp_pending,
   output logic                  rsp_pressed,
   output logic [COORD_W-1:0]    rsp_out_x,
   output logic [COORD_W-1:0]    rsp_out_y,
   output logic                  rsp_wakeup,
   output logic                  rsp_init_tried,
   output logic                  rsp_link_drop,
   output logic [POLL_W-1:0]     rsp_sleep_us,
   output logic [1:0]            rsp_host_status,

   // configuration writes
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_wdata
);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [DELAY_W-1:0] release_delay_ff;
   logic [DELAY_W-1:0] retry_interval_ff;
   logic [LIMIT_W-1:0] fail_limit_ff;
   logic [POLL_W-1:0]  poll_min_ff;
   logic [POLL_W-1:0]  poll_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         release_delay_ff  <= RELEASE_DELAY_RST;
         retry_interval_ff <= RETRY_INTERVAL_RST;
         fail_limit_ff     <= FAIL_LIMIT_RST;
         poll_min_ff       <= POLL_MIN_RST;
         poll_max_ff       <= POLL_MAX_RST;
      end else if (csr_we) begin
         // indexes past the list are ignored
         unique case (csr_index_type'(csr_index))
            CSR_RELEASE_DELAY:  release_delay_ff  <= csr_wdata[DELAY_W-1:0];
            CSR_RETRY_INTERVAL: retry_interval_ff <= csr_wdata[DELAY_W-1:0];
            CSR_FAIL_LIMIT:     fail_limit_ff     <= csr_wdata[LIMIT_W-1:0];
            CSR_POLL_MIN:       poll_min_ff       <= csr_wdata[POLL_W-1:0];
            CSR_POLL_MAX:       poll_max_ff       <= csr_wdata[POLL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Handshake: input register feeds the result register
   // ---------------------------------------------------------------------
   logic in_valid_ff;
   logic rsp_valid_ff;
   logic advance;
   logic req_fire;

   // move the held transaction forward when the result slot is empty or draining
   assign advance   = in_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;
   assign req_fire  = req_valid & req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= req_fire | (in_valid_ff & ~advance);
         rsp_valid_ff <= advance | (rsp_valid_ff & ~rsp_ready);
      end
   end

   // input payload register, no reset needed
   kind_type           in_kind_ff;
   logic [TIME_W-1:0]  in_now_ms_ff;
   logic               in_init_ok_ff;
   rd_result_type      in_read_result_ff;
   logic [CNT_W-1:0]   in_point_count_ff;
   logic [COORD_W-1:0] in_touch_x_ff;
   logic [COORD_W-1:0] in_touch_y_ff;
   logic [SIZE_W-1:0]  in_read_size_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_kind_ff        <= kind_type'(req_kind);
         in_now_ms_ff      <= req_now_ms;
         in_init_ok_ff     <= req_init_ok;
         in_read_result_ff <= rd_result_type'(req_read_result);
         in_point_count_ff <= req_point_count;
         in_touch_x_ff     <= req_touch_x;
         in_touch_y_ff     <= req_touch_y;
         in_read_size_ff   <= req_read_size;
      end
   end

   // ---------------------------------------------------------------------
   // Tracker state
   // ---------------------------------------------------------------------
   logic               online_ff,        online_in;
   logic               press_state_ff,   press_state_in;
   logic               mail_full_ff,     mail_full_in;
   logic [COORD_W-1:0] coord_x_ff,       coord_x_in;
   logic [COORD_W-1:0] coord_y_ff,       coord_y_in;
   logic [TIME_W-1:0]  last_touch_ms_ff, last_touch_ms_in;
   logic [TIME_W-1:0]  retry_at_ms_ff,   retry_at_ms_in;
   logic [LIMIT_W-1:0] fail_count_ff,    fail_count_in;
   logic [POLL_W-1:0]  poll_interval_ff, poll_interval_in;

   result_type         result;
   logic [LIMIT_W-1:0] fail_inc;
   logic [TIME_W-1:0]  elapsed;
   logic [POLL_W:0]    doubled;

   always_comb begin
      online_in        = online_ff;
      press_state_in   = press_state_ff;
      mail_full_in     = mail_full_ff;
      coord_x_in       = coord_x_ff;
      coord_y_in       = coord_y_ff;
      last_touch_ms_in = last_touch_ms_ff;
      retry_at_ms_in   = retry_at_ms_ff;
      fail_count_in    = fail_count_ff;
      poll_interval_in = poll_interval_ff;

      result             = '0;
      result.host_status = HOST_DELIVERED;

      fail_inc = fail_count_ff + 8'd1;
      elapsed  = in_now_ms_ff - last_touch_ms_ff;
      doubled  = {poll_interval_ff, 1'b0};

      if (in_kind_ff == KIND_HOST) begin
         // host read: empty the mailbox only when the record fits
         if (!mail_full_ff) begin
            result.host_status = HOST_EMPTY;
         end else if (in_read_size_ff < RECORD_BYTES) begin
            result.host_status = HOST_SMALL;
         end else begin
            mail_full_in = 1'b0;
         end
      end else if (!online_ff) begin
         // offline: try init once the retry time is reached
         if (in_now_ms_ff >= retry_at_ms_ff) begin
            result.init_tried = 1'b1;
            if (in_init_ok_ff) begin
               online_in        = 1'b1;
               fail_count_in    = '0;
               poll_interval_in = poll_min_ff;
            end else begin
               retry_at_ms_in = in_now_ms_ff + {{(TIME_W-DELAY_W){1'b0}}, retry_interval_ff};
            end
         end
         result.sleep_us = poll_max_ff;
      end else begin
         // online: count no-response reads, drop offline at the limit
         unique case (in_read_result_ff)
            RD_NORESP: begin
               if (fail_inc >= fail_limit_ff) begin
                  fail_count_in    = '0;
                  online_in        = 1'b0;
                  retry_at_ms_in   = in_now_ms_ff;
                  result.link_drop = 1'b1;
               end else begin
                  fail_count_in = fail_inc;
               end
            end
            RD_OK, RD_NODATA: begin
               fail_count_in = '0;
            end
            RD_ERROR: begin
            end
         endcase

         if (in_read_result_ff == RD_OK) begin
            if (in_point_count_ff == '0) begin
               // release only after the quiet time has passed
               if (press_state_ff &&
                   (elapsed > {{(TIME_W-DELAY_W){1'b0}}, release_delay_ff})) begin
                  press_state_in = 1'b0;
                  result.wakeup  = ~mail_full_ff;
                  mail_full_in   = 1'b1;
               end
            end else begin
               last_touch_ms_in = in_now_ms_ff;
               press_state_in   = 1'b1;
               coord_x_in       = in_touch_x_ff;
               coord_y_in       = in_touch_y_ff;
               result.wakeup    = ~mail_full_ff;
               mail_full_in     = 1'b1;
            end
         end

         // back off the poll rate unless fresh data landed
         if (result.wakeup) begin
            poll_interval_in = poll_min_ff;
         end else if (poll_interval_ff < poll_max_ff) begin
            poll_interval_in = (doubled > {1'b0, poll_max_ff}) ? poll_max_ff
                                                                : doubled[POLL_W-1:0];
         end
         result.sleep_us = poll_interval_in;
      end

      result.ready_res = online_in;
      result.pending   = mail_full_in;
      result.pressed   = press_state_in;
      result.out_x     = coord_x_in;
      result.out_y     = coord_y_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         online_ff        <= 1'b0;
         press_state_ff   <= 1'b0;
         mail_full_ff     <= 1'b0;
         coord_x_ff       <= '0;
         coord_y_ff       <= '0;
         last_touch_ms_ff <= '0;
         retry_at_ms_ff   <= '0;
         fail_count_ff    <= '0;
         poll_interval_ff <= POLL_MIN_RST;
      end else if (advance) begin
         online_ff        <= online_in;
         press_state_ff   <= press_state_in;
         mail_full_ff     <= mail_full_in;
         coord_x_ff       <= coord_x_in;
         coord_y_ff       <= coord_y_in;
         last_touch_ms_ff <= last_touch_ms_in;
         retry_at_ms_ff   <= retry_at_ms_in;
         fail_count_ff    <= fail_count_in;
         poll_interval_ff <= poll_interval_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------
   result_type rsp_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ready_res   = rsp_ff.ready_res;
   assign rsp_pending     = rsp_ff.pending;
   assign rsp_pressed     = rsp_ff.pressed;
   assign rsp_out_x       = rsp_ff.out_x;
   assign rsp_out_y       = rsp_ff.out_y;
   assign rsp_wakeup      = rsp_ff.wakeup;
   assign rsp_init_tried  = rsp_ff.init_tried;
   assign rsp_link_drop   = rsp_ff.link_drop;
   assign rsp_sleep_us    = rsp_ff.sleep_us;
   assign rsp_host_status = rsp_ff.host_status;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `TPEQ_ASSERT_NOW(a_drop_is_offline, clock, reset,
      rsp_valid && rsp_link_drop, !rsp_ready_res)
   `TPEQ_ASSERT_NOW(a_wakeup_fills_mail, clock, reset,
      rsp_valid && rsp_wakeup, rsp_pending)
   `TPEQ_ASSERT_NOW(a_host_no_poll_side, clock, reset,
      rsp_valid && (rsp_host_status != HOST_DELIVERED),
      (rsp_sleep_us == '0) && !rsp_wakeup && !rsp_init_tried)
   `TPEQ_ASSERT_NEXT(a_pending_tracks_mail, clock, reset,
      advance, rsp_pending == mail_full_ff)

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import tpeq_pkg::*;

   // One input transaction as the sender sees it.
   typedef struct {
      kind_type            kind;
      logic [TIME_W-1:0]   now_ms;
      logic                init_ok;
      rd_result_type       read_result;
      logic [CNT_W-1:0]    point_count;
      logic [COORD_W-1:0]  touch_x;
      logic [COORD_W-1:0]  touch_y;
      logic [SIZE_W-1:0]   read_size;
   } poll_item_type;

   // Clock, reset and all block inputs start at known values.
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_kind = 1'b0;
   logic [TIME_W-1:0]     req_now_ms = '0;
   logic                  req_init_ok = 1'b0;
   logic [1:0]            req_read_result = '0;
   logic [CNT_W-1:0]      req_point_count = '0;
   logic [COORD_W-1:0]    req_touch_x = '0;
   logic [COORD_W-1:0]    req_touch_y = '0;
   logic [SIZE_W-1:0]     req_read_size = '0;

   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_ready_res;
   logic                  rsp_pending;
   logic                  rsp_pressed;
   logic [COORD_W-1:0]    rsp_out_x;
   logic [COORD_W-1:0]    rsp_out_y;
   logic                  rsp_wakeup;
   logic                  rsp_init_tried;
   logic                  rsp_link_drop;
   logic [POLL_W-1:0]     rsp_sleep_us;
   logic [1:0]            rsp_host_status;

   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_W-1:0]      csr_wdata = '0;

   touch_poll_event_qualifier_top u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_now_ms      (req_now_ms),
      .req_init_ok     (req_init_ok),
      .req_read_result (req_read_result),
      .req_point_count (req_point_count),
      .req_touch_x     (req_touch_x),
      .req_touch_y     (req_touch_y),
      .req_read_size   (req_read_size),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ready_res   (rsp_ready_res),
      .rsp_pending     (rsp_pending),
      .rsp_pressed     (rsp_pressed),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_wakeup      (rsp_wakeup),
      .rsp_init_tried  (rsp_init_tried),
      .rsp_link_drop   (rsp_link_drop),
      .rsp_sleep_us    (rsp_sleep_us),
      .rsp_host_status (rsp_host_status),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // ------------------------------------------------------------------
   // Qualifier predictor: register copies and tracker state.
   // ------------------------------------------------------------------
   logic [DELAY_W-1:0]  cfg_release_delay;
   logic [DELAY_W-1:0]  cfg_retry_interval;
   logic [LIMIT_W-1:0]  cfg_fail_limit;
   logic [POLL_W-1:0]   cfg_poll_min;
   logic [POLL_W-1:0]   cfg_poll_max;

   logic                st_online;
   logic                st_pressed;
   logic                st_mail_full;
   logic [COORD_W-1:0]  st_x;
   logic [COORD_W-1:0]  st_y;
   logic [TIME_W-1:0]   st_last_touch;
   logic [TIME_W-1:0]   st_retry_at;
   logic [LIMIT_W-1:0]  st_fail_count;
   logic [POLL_W-1:0]   st_interval;

   poll_item_type  poll_backlog[$];      // transactions waiting for the driver
   result_type     expected_results[$];  // predicted results, oldest first

   poll_item_type  in_flight;
   result_type  want_res;
   int          n_queued = 0;
   int          n_accepted = 0;
   int          n_results = 0;
   int          n_errors = 0;

   // Stimulus shaping
   logic              no_idle = 1'b0;
   logic              send_gappy = 1'b1;
   logic              recv_gappy = 1'b1;
   int                send_gap = 0;
   int                recv_gap = 0;
   int                hold_left = 0;
   logic [TIME_W-1:0] gen_now = '0;
   int                gen_burst = 0;

   function automatic void reset_model();
      cfg_release_delay  = RELEASE_DELAY_RST;
      cfg_retry_interval = RETRY_INTERVAL_RST;
      cfg_fail_limit     = FAIL_LIMIT_RST;
      cfg_poll_min       = POLL_MIN_RST;
      cfg_poll_max       = POLL_MAX_RST;
      st_online     = 1'b0;
      st_pressed    = 1'b0;
      st_mail_full  = 1'b0;
      st_x          = '0;
      st_y          = '0;
      st_last_touch = '0;
      st_retry_at   = '0;
      st_fail_count = '0;
      st_interval   = POLL_MIN_RST;
   endfunction

   // Advance the tracker by one transaction and return the result it causes.
   function automatic result_type qualify_event(poll_item_type it);
      result_type        r;
      logic              woke;
      logic [POLL_W:0]   dbl;
      r = '0;
      woke = 1'b0;
      r.host_status = HOST_DELIVERED;
      if (it.kind == KIND_HOST) begin
         if (!st_mail_full)
            r.host_status = HOST_EMPTY;
         else if (it.read_size < RECORD_BYTES)
            r.host_status = HOST_SMALL;
         else
            st_mail_full = 1'b0;
      end else if (!st_online) begin
         // offline: no read evaluated, only a retry once the time has come
         if (it.now_ms >= st_retry_at) begin
            r.init_tried = 1'b1;
            if (it.init_ok) begin
               st_online     = 1'b1;
               st_fail_count = '0;
               st_interval   = cfg_poll_min;
            end else begin
               st_retry_at = it.now_ms + TIME_W'(cfg_retry_interval);
            end
         end
         r.sleep_us = cfg_poll_max;
      end else begin
         case (it.read_result)
            RD_NORESP: begin
               st_fail_count = st_fail_count + 8'd1;
               if (st_fail_count >= cfg_fail_limit) begin
                  st_fail_count = '0;
                  st_online     = 1'b0;
                  st_retry_at   = it.now_ms;
                  r.link_drop   = 1'b1;
               end
            end
            RD_OK, RD_NODATA: st_fail_count = '0;
            default: ;
         endcase
         if (it.read_result == RD_OK) begin
            if (it.point_count == '0) begin
               // release only after the delay has fully passed
               if (st_pressed &&
                   (it.now_ms - st_last_touch) > TIME_W'(cfg_release_delay)) begin
                  st_pressed   = 1'b0;
                  woke         = !st_mail_full;
                  st_mail_full = 1'b1;
               end
            end else begin
               st_last_touch = it.now_ms;
               st_pressed    = 1'b1;
               st_x          = it.touch_x;
               st_y          = it.touch_y;
               woke          = !st_mail_full;
               st_mail_full  = 1'b1;
            end
         end
         if (woke) begin
            st_interval = cfg_poll_min;
         end else if (st_interval < cfg_poll_max) begin
            dbl = {st_interval, 1'b0};
            st_interval = (dbl > {1'b0, cfg_poll_max}) ? cfg_poll_max : dbl[POLL_W-1:0];
         end
         r.sleep_us = st_interval;
      end
      r.ready_res = st_online;
      r.pending   = st_mail_full;
      r.pressed   = st_pressed;
      r.out_x     = st_x;
      r.out_y     = st_y;
      r.wakeup    = woke;
      return r;
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         n_errors++;
      end
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic poll_item_type mk_poll(logic [TIME_W-1:0] now, logic ok,
                                             rd_result_type rd,
                                             logic [CNT_W-1:0] pts, logic [COORD_W-1:0] x,
                                             logic [COORD_W-1:0] y);
      poll_item_type it;
      it.kind        = KIND_POLL;
      it.now_ms      = now;
      it.init_ok     = ok;
      it.read_result = rd;
      it.point_count = pts;
      it.touch_x     = x;
      it.touch_y     = y;
      it.read_size   = '0;
      return it;
   endfunction

   function automatic poll_item_type mk_host(logic [SIZE_W-1:0] size);
      poll_item_type it;
      it = mk_poll('0, 1'b0, RD_OK, '0, '0, '0);
      it.kind      = KIND_HOST;
      it.read_size = size;
      return it;
   endfunction

   // Random transaction along a mostly monotonic time line, with bursts of
   // not-responding reads that can run long enough to reach the fail limit.
   function automatic poll_item_type rand_item(int limit);
      poll_item_type it;
      int            sel;
      it.kind        = KIND_POLL;
      it.now_ms      = {$urandom, $urandom};
      it.init_ok     = ($urandom_range(0, 99) < 80);
      it.read_result = rd_result_type'($urandom_range(0, 3));
      it.point_count = ($urandom_range(0, 99) < 45) ? '0 : CNT_W'($urandom_range(1, 7));
      it.touch_x     = COORD_W'($urandom);
      it.touch_y     = COORD_W'($urandom);
      it.read_size   = SIZE_W'($urandom);
      if ($urandom_range(0, 99) < 22) begin
         it.kind = KIND_HOST;
         if ($urandom_range(0, 3) == 0)
            it.read_size = SIZE_W'($urandom_range(0, 7));
         return it;
      end
      sel = $urandom_range(0, 199);
      if (sel < 140)
         gen_now = gen_now + TIME_W'($urandom_range(0, 30));
      else if (sel < 176)
         gen_now = gen_now + TIME_W'($urandom_range(0, 400));
      else if (sel < 192)
         gen_now = gen_now + TIME_W'($urandom_range(0, 70000));
      else if (sel < 198)
         gen_now = gen_now - TIME_W'($urandom_range(1, 50));
      else if (sel == 198)
         gen_now = {TIME_W{1'b1}} - TIME_W'($urandom_range(0, 200));   // just short of the wrap
      else
         gen_now = gen_now + TIME_W'($urandom_range(0, 3));
      it.now_ms = gen_now;
      sel = $urandom_range(0, 99);
      if (gen_burst > 0) begin
         gen_burst--;
         it.read_result = RD_NORESP;
      end else if (sel < 3) begin
         gen_burst = $urandom_range(1, limit + 2);
         it.read_result = RD_NORESP;
      end else if (sel < 60) begin
         it.read_result = RD_OK;
      end else if (sel < 75) begin
         it.read_result = RD_NODATA;
      end else if (sel < 85) begin
         it.read_result = RD_NORESP;
      end else begin
         it.read_result = RD_ERROR;
      end
      return it;
   endfunction

   task automatic queue_item(poll_item_type it);
      poll_backlog.push_back(it);
      n_queued++;
   endtask

   // Hold until every queued transaction is in and every result is out,
   // then let the pipeline settle.
   task automatic wait_drained();
      do @(negedge clock); while (n_accepted != n_queued || expected_results.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // Write one register while the block is idle; mirror it in the predictor.
   task automatic write_csr(csr_index_type idx, logic [CSR_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_RELEASE_DELAY:  cfg_release_delay  = data[DELAY_W-1:0];
         CSR_RETRY_INTERVAL: cfg_retry_interval = data[DELAY_W-1:0];
         CSR_FAIL_LIMIT:     cfg_fail_limit     = data[LIMIT_W-1:0];
         CSR_POLL_MIN:       cfg_poll_min       = data[POLL_W-1:0];
         CSR_POLL_MAX:       cfg_poll_max       = data[POLL_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Clock and reset
   // ------------------------------------------------------------------
   initial begin
      forever #5 clock = !clock;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------
   // Driver: predict each accepted transaction, then offer the next one.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_results.push_back(qualify_event(in_flight));
            n_accepted++;
         end
         if (req_valid && !req_ready) begin
            // hold the offered transaction until it is taken
         end else if (send_gap != 0) begin
            send_gap  <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (!no_idle && send_gappy && $urandom_range(0, 99) < 20) begin
            send_gap  <= $urandom_range(0, 7);
            req_valid <= 1'b0;
         end else if (poll_backlog.size() != 0) begin
            in_flight = poll_backlog.pop_front();
            req_valid       <= 1'b1;
            req_kind        <= in_flight.kind;
            req_now_ms      <= in_flight.now_ms;
            req_init_ok     <= in_flight.init_ok;
            req_read_result <= in_flight.read_result;
            req_point_count <= in_flight.point_count;
            req_touch_x     <= in_flight.touch_x;
            req_touch_y     <= in_flight.touch_y;
            req_read_size   <= in_flight.read_size;
         end else begin
            req_valid <= 1'b0;
         end
         // switch between gappy stretches and back-to-back stretches
         if ($urandom_range(0, 63) == 0)
            send_gappy <= !send_gappy;
      end
   end

   // ------------------------------------------------------------------
   // Monitor: check each result against the oldest prediction, and
   // throttle the result side.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("result transaction with no prediction pending");
               n_errors++;
            end else begin
               want_res = expected_results.pop_front();
               check_field("ready_res",   want_res.ready_res,   rsp_ready_res);
               check_field("pending",     want_res.pending,     rsp_pending);
               check_field("pressed",     want_res.pressed,     rsp_pressed);
               check_field("out_x",       want_res.out_x,       rsp_out_x);
               check_field("out_y",       want_res.out_y,       rsp_out_y);
               check_field("wakeup",      want_res.wakeup,      rsp_wakeup);
               check_field("init_tried",  want_res.init_tried,  rsp_init_tried);
               check_field("link_drop",   want_res.link_drop,   rsp_link_drop);
               check_field("sleep_us",    want_res.sleep_us,    rsp_sleep_us);
               check_field("host_status", want_res.host_status, rsp_host_status);
            end
            n_results++;
            // long hold-off: let the block fill up and back-pressure the sender
            if (n_results == 400 || n_results == 1100)
               hold_left = 300;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (recv_gap != 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else if (!no_idle && recv_gappy && $urandom_range(0, 99) < 20) begin
            recv_gap = $urandom_range(0, 7);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
         if ($urandom_range(0, 63) == 0)
            recv_gappy <= !recv_gappy;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus sequence
   // ------------------------------------------------------------------
   initial begin
      logic [CSR_W-1:0] vals [5];
      int               cnt;

      reset_model();
      wait (reset == 1'b0);
      @(negedge clock);

      // Directed: empty mailbox read, failed init, early tick, init, press,
      // overwrite of a full mailbox, small buffer, delivery, all read outcomes,
      // release just at and just past the delay.
      queue_item(mk_host(16'hFFFF));
      queue_item(mk_poll(64'd0,    1'b0, RD_OK,     3'd0, 16'h0000, 16'h0000));
      queue_item(mk_poll(64'd500,  1'b1, RD_OK,     3'd0, 16'h0000, 16'h0000));
      queue_item(mk_poll(64'd1000, 1'b1, RD_OK,     3'd0, 16'h0000, 16'h0000));
      queue_item(mk_poll(64'd1002, 1'b1, RD_OK,     3'd3, 16'hFFFF, 16'h0000));
      queue_item(mk_poll(64'd1004, 1'b0, RD_OK,     3'd7, 16'h0000, 16'hFFFF));
      queue_item(mk_host(16'd0));
      queue_item(mk_host(16'd5));
      queue_item(mk_host(16'd6));
      queue_item(mk_host(16'hFFFF));
      queue_item(mk_poll(64'd1010, 1'b1, RD_NODATA, 3'd2, 16'h1234, 16'h5678));
      queue_item(mk_poll(64'd1012, 1'b1, RD_ERROR,  3'd4, 16'h4321, 16'h8765));
      queue_item(mk_poll(64'd1014, 1'b1, RD_NORESP, 3'd0, 16'h0000, 16'h0000));
      queue_item(mk_poll(64'd1016, 1'b1, RD_NORESP, 3'd5, 16'hAAAA, 16'h5555));
      queue_item(mk_poll(64'd1024, 1'b1, RD_OK,     3'd0, 16'h0000, 16'h0000));
      queue_item(mk_poll(64'd1025, 1'b1, RD_OK,     3'd0, 16'h0000, 16'h0000));
      queue_item(mk_poll(64'd1026, 1'b1, RD_OK,     3'd0, 16'h0000, 16'h0000));
      wait_drained();

      // Zero fail limit: first not-responding read drops the link; then a
      // retry across the 64-bit time wrap.
      write_csr(CSR_FAIL_LIMIT, '0);
      queue_item(mk_poll(64'd2000, 1'b1, RD_NORESP, 3'd0, 16'h0000, 16'h0000));
      queue_item(mk_poll(64'd1999, 1'b1, RD_OK,     3'd0, 16'h0000, 16'h0000));
      queue_item(mk_poll(64'hFFFF_FFFF_FFFF_FFF0, 1'b0, RD_OK, 3'd0, 16'h0, 16'h0));
      queue_item(mk_poll(64'h10,   1'b1, RD_OK,     3'd0, 16'h0000, 16'h0000));
      queue_item(mk_poll(64'h3D8,  1'b1, RD_OK,     3'd0, 16'h0000, 16'h0000));
      queue_item(mk_poll(64'h3E0,  1'b1, RD_OK,     3'd2, 16'h1234, 16'h5678));
      wait_drained();
      gen_now = 64'h3E0;

      // Random phases, each under its own register setting.
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin
               vals = '{CSR_W'(RELEASE_DELAY_RST), CSR_W'(RETRY_INTERVAL_RST),
                        CSR_W'(FAIL_LIMIT_RST), CSR_W'(POLL_MIN_RST),
                        CSR_W'(POLL_MAX_RST)};
               cnt = 500;
            end
            1: begin
               vals = '{20'h0, 20'h0, 20'h1, 20'h1, 20'hFFFFF};
               cnt = 300;
            end
            2: begin
               // min above max, widest delays and limit
               vals = '{20'hFFFF, 20'hFFFF, 20'hFF, 20'hFFFFF, 20'h1};
               cnt = 250;
            end
            5: begin
               vals = '{20'd5, 20'd50, 20'd3, 20'd100, 20'd3200};
               cnt = 250;
               no_idle = 1'b1;
            end
            default: begin
               vals[0] = CSR_W'($urandom_range(0, 16'hFFFF));
               vals[1] = CSR_W'($urandom_range(0, 3000));
               vals[2] = CSR_W'($urandom_range(0, 8'hFF));
               vals[3] = CSR_W'($urandom_range(0, 20'hFFFFF));
               vals[4] = CSR_W'($urandom_range(0, 20'hFFFFF));
               cnt = 300;
            end
         endcase
         write_csr(CSR_RELEASE_DELAY,  vals[0]);
         write_csr(CSR_RETRY_INTERVAL, vals[1]);
         write_csr(CSR_FAIL_LIMIT,     vals[2]);
         write_csr(CSR_POLL_MIN,       vals[3]);
         write_csr(CSR_POLL_MAX,       vals[4]);
         gen_burst = 0;
         for (int n = 0; n < cnt; n++)
            queue_item(rand_item(int'(vals[2][LIMIT_W-1:0])));
         // sender pauses here until every prediction has been met
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (n_errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // Run limit, far above the slowest correct run.
   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
